### rtl/kfp_pkg.sv
package kfp_pkg;

    // Sizing
    localparam int COORD_BITS = 12;
    localparam int MAX_ORDER  = 8;
    localparam int MAX_LEVELS = 12;
    localparam int CFG_W      = 4;
    localparam int PAT_W      = MAX_ORDER * MAX_ORDER;
    localparam int DATA_W     = 64;
    localparam int DIG_W      = $clog2(MAX_ORDER);
    localparam int DIV_W      = DIG_W + 1;
    localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
    localparam int CNT_W      = $clog2(COORD_BITS);
    localparam int CIDX_W     = 2;
    localparam int PIDX_W     = 2 * DIG_W;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_ORDER   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_LEVELS  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_PATTERN = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] ORDER_RST  = 4'd2;
    localparam logic [CFG_W-1:0] LEVELS_RST = 4'd1;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
    } kfp_req_t;

    typedef struct packed {
        logic pixel_set;
        logic out_of_range;
    } kfp_rsp_t;

    // Sequencer <-> divider handshake
    typedef struct packed {
        logic                  load;
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic [DIV_W-1:0]      divisor;
    } kfp_div_cmd_t;

    typedef struct packed {
        logic                  done;
        logic [COORD_BITS-1:0] quo_row;
        logic [COORD_BITS-1:0] quo_col;
        logic [DIG_W-1:0]      rem_row;
        logic [DIG_W-1:0]      rem_col;
    } kfp_div_sts_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } kfp_state_t;

endpackage

### rtl/kronecker_fractal_pixel_top.sv
// Each query runs the bit-serial divider once per level, k = effective levels, from the
// accepting edge to done; no new query is taken until the previous result is out.
// Busy drops as done rises.
// Reset (rst_n, async, active low): order=2, levels=1, pattern=0, sequencer idle.
// Results show on rsp for the single cycle done is high; the receiver cannot stall.
module kronecker_fractal_pixel_top
    import kfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  kfp_req_t          req,
    output logic              done,
    output kfp_rsp_t          rsp,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0] cfg_wdata
);

    logic [CFG_W-1:0] order_reg, levels_reg;
    logic [PAT_W-1:0] pattern_reg;

    kfp_state_t       state_reg, state_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             set_reg, set_next;
    logic             done_reg, done_next;
    kfp_rsp_t         rsp_reg, rsp_next;

    logic [DIV_W-1:0] eff_n;
    logic [LVL_W-1:0] eff_k;
    logic             accept;
    logic             cell_bit;
    logic             last_lvl;
    logic             oor;

    kfp_div_cmd_t     div_cmd;
    kfp_div_sts_t     div_sts;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg   <= ORDER_RST;
            levels_reg  <= LEVELS_RST;
            pattern_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ORDER:   order_reg   <= cfg_wdata[CFG_W-1:0];
                REG_LEVELS:  levels_reg  <= cfg_wdata[CFG_W-1:0];
                REG_PATTERN: pattern_reg <= cfg_wdata[PAT_W-1:0];
                default:     ;
            endcase
        end
    end

    // Saturated order and level count
    always_comb
    begin
        if (order_reg < CFG_W'(2))
            eff_n = DIV_W'(2);
        else if (order_reg > CFG_W'(MAX_ORDER))
            eff_n = DIV_W'(MAX_ORDER);
        else
            eff_n = DIV_W'(order_reg);
        if (levels_reg == '0)
            eff_k = LVL_W'(1);
        else if (levels_reg > CFG_W'(MAX_LEVELS))
            eff_k = LVL_W'(MAX_LEVELS);
        else
            eff_k = LVL_W'(levels_reg);
    end

    assign accept   = start && (state_reg == ST_IDLE);
    assign cell_bit = pattern_reg[{div_sts.rem_row, div_sts.rem_col}];
    assign last_lvl = (lvl_reg == (eff_k - 1'b1));
    // Leftover quotient after k digits means the coordinate is past n^k
    assign oor      = (div_sts.quo_row != '0) || (div_sts.quo_col != '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept)
                    state_next = ST_RUN;
            ST_RUN:
                if (div_sts.done && last_lvl)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs and datapath updates
    always_comb
    begin
        lvl_next        = lvl_reg;
        set_next        = set_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        div_cmd.load    = 1'b0;
        div_cmd.row     = req.row;
        div_cmd.col     = req.col;
        div_cmd.divisor = eff_n;
        case (state_reg)
            ST_IDLE:
                if (accept)
                begin
                    div_cmd.load = 1'b1;
                    lvl_next     = '0;
                    set_next     = 1'b1;
                end
            ST_RUN:
                begin
                    div_cmd.row = div_sts.quo_row;
                    div_cmd.col = div_sts.quo_col;
                    if (div_sts.done)
                    begin
                        set_next = set_reg && cell_bit;
                        if (last_lvl)
                        begin
                            done_next             = 1'b1;
                            rsp_next.out_of_range = oor;
                            rsp_next.pixel_set    = set_reg && cell_bit && !oor;
                        end
                        else
                        begin
                            div_cmd.load = 1'b1;
                            lvl_next     = lvl_reg + 1'b1;
                        end
                    end
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            lvl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            lvl_reg   <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        set_reg <= set_next;
        rsp_reg <= rsp_next;
    end

    kfp_div_unit u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .sts   (div_sts)
    );

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### rtl/kfp_div_unit.sv
// Restoring divider, one quotient bit per cycle, row and column lanes in step
module kfp_div_unit
    import kfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  kfp_div_cmd_t cmd,
    output kfp_div_sts_t sts
);

    logic                  running_reg, running_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIV_W-1:0]      div_reg, div_next;
    logic [COORD_BITS-1:0] qr_reg, qr_next, qc_reg, qc_next;
    logic [DIG_W-1:0]      rr_reg, rr_next, rc_reg, rc_next;

    logic [DIV_W-1:0]      shr, shc;
    logic                  ger, gec;
    logic [DIV_W-1:0]      subr, subc;

    // One step: shift next dividend bit into the partial remainder
    always_comb
    begin
        shr  = {rr_reg, qr_reg[COORD_BITS-1]};
        shc  = {rc_reg, qc_reg[COORD_BITS-1]};
        ger  = (shr >= div_reg);
        gec  = (shc >= div_reg);
        subr = ger ? (shr - div_reg) : shr;
        subc = gec ? (shc - div_reg) : shc;
    end

    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        div_next     = div_reg;
        qr_next      = qr_reg;
        qc_next      = qc_reg;
        rr_next      = rr_reg;
        rc_next      = rc_reg;
        if (cmd.load)
        begin
            running_next = 1'b1;
            cnt_next     = '0;
            div_next     = cmd.divisor;
            qr_next      = cmd.row;
            qc_next      = cmd.col;
            rr_next      = '0;
            rc_next      = '0;
        end
        else if (running_reg)
        begin
            qr_next  = {qr_reg[COORD_BITS-2:0], ger};
            qc_next  = {qc_reg[COORD_BITS-2:0], gec};
            rr_next  = subr[DIG_W-1:0];
            rc_next  = subc[DIG_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(COORD_BITS - 1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
        qr_reg  <= qr_next;
        qc_reg  <= qc_next;
        rr_reg  <= rr_next;
        rc_reg  <= rc_next;
    end

    assign sts.done    = done_reg;
    assign sts.quo_row = qr_reg;
    assign sts.quo_col = qc_reg;
    assign sts.rem_row = rr_reg;
    assign sts.rem_col = rc_reg;

endmodule

### rtl/kfp_checker.sv
module kfp_checker
    import kfp_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input logic     done,
    input kfp_rsp_t rsp
);

    // An accepted item raises busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    // Result strobe is a single-cycle pulse
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // Busy drops exactly when the result is shown
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // Out-of-range pixels read as clear
    a_oor_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.out_of_range && rsp.pixel_set))
        else $error("out-of-range result with pixel set");

endmodule

bind kronecker_fractal_pixel_top kfp_checker u_kfp_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

### sim/kfp_pixel_checker.sv
`timescale 1ns / 100ps

module kfp_pixel_checker
    import kfp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  kfp_req_t          req,
    input  logic              done,
    input  kfp_rsp_t          rsp,
    input  logic              cfg_we,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0] cfg_wdata,
    output int                mismatches,
    output int                outstanding
);

    // Shadow copy of the block's registers
    logic [CFG_W-1:0] cur_order;
    logic [CFG_W-1:0] cur_levels;
    logic [PAT_W-1:0] cur_pattern;

    // Expected pixels in query order
    kfp_rsp_t pending_pixels[$];

    // Pixel of the Kronecker power picture at one coordinate pair
    function automatic kfp_rsp_t pixel_lookup(kfp_req_t q);
        int       n;
        int       k;
        int       side;
        bit       capped;
        int       r;
        int       c;
        int       bit_idx;
        kfp_rsp_t res;

        n = cur_order;
        if (n < 2) n = 2;
        if (n > MAX_ORDER) n = MAX_ORDER;
        k = cur_levels;
        if (k < 1) k = 1;
        if (k > MAX_LEVELS) k = MAX_LEVELS;

        // side of the picture, no range check once it covers every coordinate
        side = 1;
        capped = 1'b0;
        for (int l = 0; l < k && !capped; l++)
        begin
            side = side * n;
            if (side >= (1 << COORD_BITS)) capped = 1'b1;
        end

        r = q.row;
        c = q.col;
        res.pixel_set = 1'b1;
        res.out_of_range = 1'b0;
        if (!capped && (r >= side || c >= side))
        begin
            res.pixel_set = 1'b0;
            res.out_of_range = 1'b1;
            return res;
        end

        // one base cell per level, least significant digit first
        for (int l = 0; l < k; l++)
        begin
            bit_idx = (r % n) * 8 + (c % n);
            if (!cur_pattern[bit_idx]) res.pixel_set = 1'b0;
            r = r / n;
            c = c / n;
        end
        return res;
    endfunction

    // Predict on accepted items, compare on each strobe, track the registers
    always @(posedge clk or negedge rst_n)
    begin
        kfp_rsp_t want;
        int       errs;

        errs = 0;
        if (!rst_n)
        begin
            cur_order   <= ORDER_RST;
            cur_levels  <= LEVELS_RST;
            cur_pattern <= '0;
            pending_pixels.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $error("result with no query outstanding: pixel_set=%0d out_of_range=%0d",
                           rsp.pixel_set, rsp.out_of_range);
                    errs++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (rsp.pixel_set !== want.pixel_set)
                    begin
                        $error("pixel_set: expected %0d, got %0d",
                               want.pixel_set, rsp.pixel_set);
                        errs++;
                    end
                    if (rsp.out_of_range !== want.out_of_range)
                    begin
                        $error("out_of_range: expected %0d, got %0d",
                               want.out_of_range, rsp.out_of_range);
                        errs++;
                    end
                end
            end

            if (start && !busy)
                pending_pixels.insert(pending_pixels.size(), pixel_lookup(req));

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ORDER:   cur_order   <= cfg_wdata[CFG_W-1:0];
                    REG_LEVELS:  cur_levels  <= cfg_wdata[CFG_W-1:0];
                    REG_PATTERN: cur_pattern <= cfg_wdata[PAT_W-1:0];
                    default:     ;
                endcase
            end

            mismatches  <= mismatches + errs;
            outstanding <= pending_pixels.size();
        end
    end

endmodule

### sim/kronecker_fractal_pixel_top_test.sv
`timescale 1ns / 100ps

module kronecker_fractal_pixel_top_test
    import kfp_pkg::*;
();

    localparam int LIMIT = 600000;
    localparam int RANDOM_ITEMS = 600;
    localparam int CALM_TAIL = 80;
    localparam int DRAIN_CYCLES = 200;
    localparam logic [CIDX_W-1:0] REG_UNUSED = 2'd3;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    kfp_req_t          req;
    logic              done;
    kfp_rsp_t          rsp;
    logic              cfg_we;
    logic [CIDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_wdata;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int pic_side;
    bit idle_on;

    kronecker_fractal_pixel_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    kfp_pixel_checker u_pixel_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req         (req),
        .done        (done),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Picture side for stimulus shaping, held at 4096 once it covers the field
    function automatic int picture_side(logic [CFG_W-1:0] ord, logic [CFG_W-1:0] lvl);
        int n;
        int k;
        int side;

        n = ord;
        if (n < 2) n = 2;
        if (n > MAX_ORDER) n = MAX_ORDER;
        k = lvl;
        if (k < 1) k = 1;
        if (k > MAX_LEVELS) k = MAX_LEVELS;
        side = 1;
        for (int l = 0; l < k && side < (1 << COORD_BITS); l++)
            side = side * n;
        if (side > (1 << COORD_BITS)) side = 1 << COORD_BITS;
        return side;
    endfunction

    // Mostly inside the picture, with edges and stray values mixed in
    function automatic logic [COORD_BITS-1:0] pick_coord(int side);
        int sel;

        sel = $urandom_range(0, 9);
        if (side >= (1 << COORD_BITS) || sel == 9) return COORD_BITS'($urandom);
        if (sel == 8) return COORD_BITS'(side);
        if (sel == 7) return COORD_BITS'(side - 1);
        return COORD_BITS'($urandom_range(0, side - 1));
    endfunction

    // One register write, enable dropped on the following edge
    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Hold off until every expected pixel is back and the block is idle
    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0 || busy);
    endtask

    // Load all three registers; upper bits of the 4-bit ones carry junk
    task automatic set_config(input logic [CFG_W-1:0] ord, input logic [CFG_W-1:0] lvl,
                              input logic [PAT_W-1:0] pat);
        logic [DATA_W-1:0] junk;

        settle();
        junk = {$urandom, $urandom};
        write_reg(REG_ORDER, {junk[DATA_W-1:CFG_W], ord});
        junk = {$urandom, $urandom};
        write_reg(REG_LEVELS, {junk[DATA_W-1:CFG_W], lvl});
        write_reg(REG_PATTERN, pat);
        pic_side = picture_side(ord, lvl);
    endtask

    // Present one query and return right after the edge that takes it
    task automatic query_pixel(input logic [COORD_BITS-1:0] r, input logic [COORD_BITS-1:0] c);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            if ($urandom_range(0, 1))
            begin
                do
                    @(posedge clk);
                while (busy);
            end
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req.row <= r;
        req.col <= c;
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    initial
    begin
        logic [CFG_W-1:0] ord;
        logic [CFG_W-1:0] lvl;
        logic [PAT_W-1:0] pat;
        int               sent;
        int               phase_len;

        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        idle_on     = 1'b0;
        pic_side    = picture_side(ORDER_RST, LEVELS_RST);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: empty 2x2 pattern, one level
        query_pixel(12'd0, 12'd0);
        query_pixel(12'd1, 12'd1);
        query_pixel(12'd2, 12'd0);
        query_pixel(12'd0, 12'd4095);

        // Largest order-2 side that still has a range check
        set_config(4'd2, 4'd11, '1);
        query_pixel(12'd2047, 12'd2047);
        query_pixel(12'd2048, 12'd5);

        // Side of exactly 4096: nothing is out of range; corner cell cleared
        set_config(4'd4, 4'd6, ~(64'd1 << (3 * 8 + 3)));
        query_pixel(12'd4095, 12'd4095);
        query_pixel(12'd4095, 12'd0);

        // 3x3 carpet, two levels
        set_config(4'd3, 4'd2, 64'h0000_0000_0007_0507);
        query_pixel(12'd4, 12'd4);
        query_pixel(12'd3, 12'd0);
        query_pixel(12'd8, 12'd8);
        query_pixel(12'd9, 12'd0);
        query_pixel(12'd0, 12'd9);

        // Only cells outside the 3x3 corner are set, so all pixels clear
        set_config(4'd3, 4'd2, ~64'h0000_0000_0007_0707);
        query_pixel(12'd0, 12'd0);
        query_pixel(12'd8, 12'd8);

        // Order and levels below range saturate; a write to the spare index is dropped
        set_config(4'd0, 4'd0, 64'h0000_0000_0000_0103);
        write_reg(REG_UNUSED, '1);
        query_pixel(12'd1, 12'd1);
        query_pixel(12'd1, 12'd0);
        query_pixel(12'd2, 12'd0);

        // Order and levels above range saturate to 8 and 12
        set_config(4'd15, 4'd15, {$urandom, $urandom} | 64'h8000_0000_0000_0001);
        query_pixel(12'd4095, 12'd4095);
        query_pixel(12'd0, 12'd0);
        query_pixel(12'hAAA, 12'h555);

        // Odd order, side 2401
        set_config(4'd7, 4'd4, '1);
        query_pixel(12'd2400, 12'd2400);
        query_pixel(12'd2401, 12'd0);

        // Random phases, each with fresh settings
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) < 7) ord = CFG_W'($urandom_range(2, 8));
            else ord = CFG_W'($urandom_range(0, 15));
            case ($urandom_range(0, 19))
                0, 1, 2:    lvl = CFG_W'($urandom_range(0, 15));
                3, 4, 5, 6: lvl = CFG_W'($urandom_range(5, 12));
                default:    lvl = CFG_W'($urandom_range(1, 4));
            endcase
            case ($urandom_range(0, 4))
                0:       pat = '1;
                1:       pat = {$urandom, $urandom};
                2:       pat = {$urandom, $urandom} & {$urandom, $urandom};
                default: pat = {$urandom, $urandom} | {$urandom, $urandom}
                               | {$urandom, $urandom};
            endcase
            set_config(ord, lvl, pat);
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNUSED, {$urandom, $urandom});

            phase_len = $urandom_range(15, 50);
            for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++)
            begin
                idle_on = (sent < RANDOM_ITEMS - CALM_TAIL) && ($urandom_range(0, 3) != 0);
                if (sent == RANDOM_ITEMS / 2 || (idle_on && $urandom_range(0, 49) == 0))
                    settle();
                query_pixel(pick_coord(pic_side), pick_coord(pic_side));
                sent++;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/kfp_pkg.sv
rtl/kfp_div_unit.sv
rtl/kronecker_fractal_pixel_top.sv
rtl/kfp_checker.sv
sim/kfp_pixel_checker.sv
sim/kronecker_fractal_pixel_top_test.sv
